// ===== design/subpicture_rle_field_decoder_macros.svh =====
// assertion helpers shared by the decoder modules
`ifndef SUBPICTURE_RLE_FIELD_DECODER_MACROS_SVH
`define SUBPICTURE_RLE_FIELD_DECODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define SRLE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srle assertion failed");

// next-cycle implication, disabled during reset
`define SRLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srle assertion failed");

`endif

// ===== design/srle_pkg.sv =====
package srle_pkg;

   localparam int unsigned SIDE_W = 13;
   localparam int unsigned POS_W  = 12;
   localparam int unsigned CODE_W = 12;
   localparam int unsigned HELD_W = 2;

   // code completion limits after one, two and three nibbles
   localparam logic [15:0] CODE_LIM1   = 16'h0004;
   localparam logic [15:0] CODE_LIM2   = 16'h0010;
   localparam logic [15:0] CODE_LIM3   = 16'h0040;
   localparam logic [15:0] COLOUR_MASK = 16'h0003;

   localparam logic [SIDE_W-1:0] WIDTH_RESET  = 13'd720;
   localparam logic [SIDE_W-1:0] HEIGHT_RESET = 13'd480;

   typedef enum logic [0:0] {
      CSR_PIC_WIDTH  = 1'b0,
      CSR_PIC_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [POS_W-1:0]  run_row;
      logic [POS_W-1:0]  run_col;
      logic [SIDE_W-1:0] run_len;
      logic [1:0]        colour;
      logic              field_done;
      logic              last_of_item;
   } run_type;

   typedef struct packed {
      logic [SIDE_W-1:0] row;
      logic [SIDE_W-1:0] col;
      logic [CODE_W-1:0] partial;
      logic [HELD_W-1:0] held;
      logic              fin;
   } dec_state_type;

   typedef struct packed {
      logic [1:0] count;
      run_type    first;
      run_type    second;
   } byte_result_type;

endpackage

// ===== design/srle_ifs.sv =====
interface srle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       field_start;
   logic       bottom_field;

   modport source (output valid, data_byte, field_start, bottom_field, input ready);
   modport sink   (input valid, data_byte, field_start, bottom_field, output ready);
endinterface

interface srle_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] run_row;
   logic [11:0] run_col;
   logic [12:0] run_len;
   logic [1:0]  colour;
   logic        field_done;
   logic        last_of_item;

   modport source (output valid, run_row, run_col, run_len, colour, field_done,
                   last_of_item, input ready);
   modport sink   (input valid, run_row, run_col, run_len, colour, field_done,
                   last_of_item, output ready);
endinterface

// ===== design/srle_nib_step.sv =====
module srle_nib_step
   import srle_pkg::*;
(
   input  dec_state_type     st_in,
   input  logic [3:0]        nib,
   input  logic [SIDE_W-1:0] width,
   input  logic [SIDE_W-1:0] height,
   output dec_state_type     st_out,
   output logic              done,
   output logic              line_end,
   output run_type           run
);

   logic [15:0]       value;
   logic [2:0]        held_inc;
   logic [SIDE_W-1:0] remain;
   logic [SIDE_W:0]   run_raw;
   logic [SIDE_W:0]   run_clip;
   logic [SIDE_W:0]   col_sum;
   logic [SIDE_W-1:0] row_next;
   logic              row_over;

   assign value    = {st_in.partial, nib};
   assign held_inc = {1'b0, st_in.held} + 3'd1;

   always_comb begin
      case (held_inc)
         3'd1:    done = value >= CODE_LIM1;
         3'd2:    done = value >= CODE_LIM2;
         3'd3:    done = value >= CODE_LIM3;
         default: done = 1'b1;
      endcase
   end

   // column already at or past the width gives a one-pixel run
   assign remain   = (st_in.col < width) ? (width - st_in.col) : 13'd1;
   assign run_raw  = value[15:2];
   assign run_clip = ((run_raw == '0) || (run_raw > {1'b0, remain})) ? {1'b0, remain}
                                                                      : run_raw;
   assign col_sum  = {1'b0, st_in.col} + run_clip;
   assign line_end = done && (col_sum >= {1'b0, width});
   assign row_next = st_in.row + 13'd2;
   assign row_over = row_next >= height;

   always_comb begin
      st_out = st_in;
      if (!done) begin
         st_out.partial = value[CODE_W-1:0];
         st_out.held    = held_inc[HELD_W-1:0];
      end else begin
         st_out.partial = '0;
         st_out.held    = '0;
         if (line_end) begin
            st_out.col = '0;
            st_out.row = row_next;
            st_out.fin = row_over;
         end else begin
            st_out.col = col_sum[SIDE_W-1:0];
         end
      end
   end

   always_comb begin
      run.run_row      = st_in.row[POS_W-1:0];
      run.run_col      = st_in.col[POS_W-1:0];
      run.run_len      = run_clip[SIDE_W-1:0];
      run.colour       = value[1:0] & COLOUR_MASK[1:0];
      run.field_done   = line_end && row_over;
      run.last_of_item = 1'b0;
   end

endmodule

// ===== design/srle_byte_dec.sv =====
module srle_byte_dec
   import srle_pkg::*;
(
   input  logic [7:0]        data_byte,
   input  logic              field_start,
   input  logic              bottom_field,
   input  dec_state_type     st_in,
   input  logic [SIDE_W-1:0] width,
   input  logic [SIDE_W-1:0] height,
   output dec_state_type     st_out,
   output byte_result_type   result
);

   dec_state_type pre;
   dec_state_type st_hi;
   dec_state_type st_lo;
   logic          done_hi, done_lo;
   logic          end_hi;
   run_type       run_hi, run_lo;
   logic          act_hi, act_lo;
   logic          take_hi, take_lo;

   // field start, then the past-the-bottom check
   always_comb begin
      pre = st_in;
      if (field_start) begin
         pre.row     = {12'd0, bottom_field};
         pre.col     = '0;
         pre.partial = '0;
         pre.held    = '0;
         pre.fin     = 1'b0;
      end
      if (!pre.fin && (pre.row >= height)) begin
         pre.fin = 1'b1;
      end
   end

   srle_nib_step u_step_hi (
      .st_in    (pre),
      .nib      (data_byte[7:4]),
      .width    (width),
      .height   (height),
      .st_out   (st_hi),
      .done     (done_hi),
      .line_end (end_hi),
      .run      (run_hi)
   );

   srle_nib_step u_step_lo (
      .st_in    (st_hi),
      .nib      (data_byte[3:0]),
      .width    (width),
      .height   (height),
      .st_out   (st_lo),
      .done     (done_lo),
      .line_end (),
      .run      (run_lo)
   );

   // a line end on the high nibble drops the low nibble
   assign act_hi  = !pre.fin;
   assign act_lo  = act_hi && !end_hi;
   assign take_hi = act_hi && done_hi;
   assign take_lo = act_lo && done_lo;

   always_comb begin
      if (act_lo) begin
         st_out = st_lo;
      end else if (act_hi) begin
         st_out = st_hi;
      end else begin
         st_out = pre;
      end
   end

   always_comb begin
      result.first  = run_hi;
      result.second = run_lo;
      result.second.last_of_item = 1'b1;
      case ({take_hi, take_lo})
         2'b11: begin
            result.count = 2'd2;
         end
         2'b10: begin
            result.count = 2'd1;
            result.first.last_of_item = 1'b1;
         end
         2'b01: begin
            result.count = 2'd1;
            result.first = run_lo;
            result.first.last_of_item = 1'b1;
         end
         default: begin
            result.count = 2'd0;
         end
      endcase
   end

endmodule

// ===== design/srle_rsp_buf.sv =====
`include "subpicture_rle_field_decoder_macros.svh"

module srle_rsp_buf
   import srle_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  byte_result_type load_data,
   output logic            load_ok,
   srle_rsp_if.source      rsp_bus
);

   logic [1:0] cnt_ff, cnt_in;
   run_type    slot0_ff, slot0_in;
   run_type    slot1_ff, slot1_in;
   logic       pop;

   assign pop     = rsp_bus.valid && rsp_bus.ready;
   // loads only into a buffer that is empty after this cycle's pop
   assign load_ok = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_bus.ready);

   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (load) begin
         cnt_in   = load_data.count;
         slot0_in = load_data.first;
         slot1_in = load_data.second;
      end else if (pop) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_bus.valid        = cnt_ff != 2'd0;
   assign rsp_bus.run_row      = slot0_ff.run_row;
   assign rsp_bus.run_col      = slot0_ff.run_col;
   assign rsp_bus.run_len      = slot0_ff.run_len;
   assign rsp_bus.colour       = slot0_ff.colour;
   assign rsp_bus.field_done   = slot0_ff.field_done;
   assign rsp_bus.last_of_item = slot0_ff.last_of_item;

   `SRLE_ASSERT_NOW(a_cnt_max, clock, reset, 1'b1, cnt_ff != 2'd3)
   `SRLE_ASSERT_NEXT(a_two_loaded, clock, reset, load && (load_data.count == 2'd2),
                     cnt_ff == 2'd2)
   `SRLE_ASSERT_NEXT(a_full_stall, clock, reset, (cnt_ff == 2'd2) && !rsp_bus.ready,
                     (cnt_ff == 2'd2) && $stable(slot0_ff))

endmodule

// ===== design/subpicture_rle_field_decoder.sv =====
// subpicture run-length field decoder
// req_bus carries one byte of field pixel data per request, high nibble
// first; field_start with bottom_field opens a field on row 0 or row 1.
// rsp_bus gives one run per transfer: row, column, clipped length, colour,
// field_done on the run that ends the field's last line, and last_of_item
// on the final run caused by a request.
// csr_we/csr_index/csr_wdata write pic_width (index 0) and pic_height
// (index 1); values are clamped to 1..MAX_SIDE when written.
// a request is registered on acceptance and decoded from that register
// into a two-entry result buffer once the buffer can take its runs; its
// runs are then offered on rsp_bus from that buffer.
// throughput: one request per cycle while rsp_ready is high and each
// yields at most one run; a request that yields two holds the next one
// back, as the result buffer drains one run a cycle.
// reset: sizes go to 720 by 480, the decoder is idle until a field start,
// and both channels are empty.
// stall: with rsp_ready low and runs buffered, the buffer holds them, the
// input register keeps its request and req_ready falls once it is occupied.
`include "subpicture_rle_field_decoder_macros.svh"

module subpicture_rle_field_decoder
   import srle_pkg::*;
#(
   parameter int unsigned MAX_SIDE = 4096
) (
   input  logic              clock,
   input  logic              reset,
   srle_req_if.sink          req_bus,
   srle_rsp_if.source        rsp_bus,
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [SIDE_W-1:0] csr_wdata
);

   localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);
   localparam logic [SIDE_W-1:0] WIDTH_INIT  =
      (WIDTH_RESET > SIDE_MAX) ? SIDE_MAX : WIDTH_RESET;
   localparam logic [SIDE_W-1:0] HEIGHT_INIT =
      (HEIGHT_RESET > SIDE_MAX) ? SIDE_MAX : HEIGHT_RESET;

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
      logic [SIDE_W-1:0] r;
      if (v == '0) begin
         r = 13'd1;
      end else if (v > SIDE_MAX) begin
         r = SIDE_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // size registers, stored already clamped
   logic [SIDE_W-1:0] width_ff, width_in;
   logic [SIDE_W-1:0] height_ff, height_in;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_fs_ff;
   logic       in_bf_ff;

   // decoder state
   dec_state_type   st_ff, st_in;
   dec_state_type   st_next;
   byte_result_type byte_res;

   logic load_ok;
   logic proc;
   logic accept;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PIC_WIDTH:  width_in  = clamp_side(csr_wdata);
            CSR_PIC_HEIGHT: height_in = clamp_side(csr_wdata);
            default: ;
         endcase
      end
   end

   // the held request is decoded once the result buffer can take its runs
   assign proc          = in_valid_ff && load_ok;
   assign req_bus.ready = !in_valid_ff || proc;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   srle_byte_dec u_byte_dec (
      .data_byte    (in_byte_ff),
      .field_start  (in_fs_ff),
      .bottom_field (in_bf_ff),
      .st_in        (st_ff),
      .width        (width_ff),
      .height       (height_ff),
      .st_out       (st_next),
      .result       (byte_res)
   );

   assign st_in = proc ? st_next : st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_INIT;
         height_ff   <= HEIGHT_INIT;
         in_valid_ff <= 1'b0;
         st_ff       <= '{row: '0, col: '0, partial: '0, held: '0, fin: 1'b1};
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         in_valid_ff <= in_valid_in;
         st_ff       <= st_in;
      end
      if (accept) begin
         in_byte_ff <= req_bus.data_byte;
         in_fs_ff   <= req_bus.field_start;
         in_bf_ff   <= req_bus.bottom_field;
      end
   end

   srle_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (proc),
      .load_data (byte_res),
      .load_ok   (load_ok),
      .rsp_bus   (rsp_bus)
   );

   // idle decoder without a field start yields nothing
   `SRLE_ASSERT_NOW(a_idle_silent, clock, reset, proc && st_ff.fin && !in_fs_ff,
                    byte_res.count == 2'd0)
   // the field's last run is always the last run of its request
   `SRLE_ASSERT_NOW(a_done_is_last, clock, reset, rsp_bus.valid && rsp_bus.field_done,
                    rsp_bus.last_of_item)
   `SRLE_ASSERT_NEXT(a_accept_held, clock, reset, accept, in_valid_ff)

endmodule

// ===== tb/sv/tb_subpicture_rle_field_decoder.sv =====
module tb_subpicture_rle_field_decoder;
   import srle_pkg::*;

   // largest usable side, matching the block's default parameter
   localparam int unsigned SIDE_LIMIT = 4096;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [0:0]        csr_index;
   logic [SIDE_W-1:0] csr_wdata;

   srle_req_if req_bus ();
   srle_rsp_if rsp_bus ();

   subpicture_rle_field_decoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // tracks the decoder state and keeps the runs still owed by the block
   class field_run_tracker;
      logic [SIDE_W-1:0] width_reg  = WIDTH_RESET;
      logic [SIDE_W-1:0] height_reg = HEIGHT_RESET;
      int unsigned       row        = 0;
      int unsigned       col        = 0;
      logic [CODE_W-1:0] partial    = '0;
      logic [HELD_W-1:0] held       = '0;
      bit                field_closed = 1'b1;
      run_type           due_runs[$];
      int                errors       = 0;
      int                runs_checked = 0;
      int                fields_ended = 0;

      function int unsigned usable_side(logic [SIDE_W-1:0] v);
         if (v == 0) return 1;
         if (v > SIDE_LIMIT) return SIDE_LIMIT;
         return 32'(v);
      endfunction

      function void set_size(csr_index_type idx, logic [SIDE_W-1:0] v);
         case (idx)
            CSR_PIC_WIDTH:  width_reg = v;
            CSR_PIC_HEIGHT: height_reg = v;
            default: ;
         endcase
      endfunction

      // note an accepted request; returns 0 when the decoder ignores it
      function bit take_byte(logic [7:0] b, logic fs, logic bf);
         int unsigned w;
         int unsigned h;
         int unsigned run;
         int unsigned remain;
         logic [15:0] value;
         logic [3:0]  nib;
         bit          done;
         run_type     made[2];
         int          n;
         w = usable_side(width_reg);
         h = usable_side(height_reg);
         n = 0;
         if (fs) begin
            row = {31'd0, bf};
            col = 0;
            partial = '0;
            held = '0;
            field_closed = 1'b0;
         end
         if (!field_closed && row >= h) field_closed = 1'b1;
         if (field_closed) return 1'b0;
         for (int pos = 0; pos < 2; pos++) begin
            nib = (pos == 0) ? b[7:4] : b[3:0];
            value = {partial, nib};
            case (held)
               2'd0: done = value >= CODE_LIM1;
               2'd1: done = value >= CODE_LIM2;
               2'd2: done = value >= CODE_LIM3;
               default: done = 1'b1;
            endcase
            if (!done) begin
               partial = value[CODE_W-1:0];
               held = held + 1'b1;
               continue;
            end
            partial = '0;
            held = '0;
            run = 32'(value >> 2);
            remain = (col < w) ? (w - col) : 1;
            if (run == 0 || run > remain) run = remain;
            made[n].run_row      = row[POS_W-1:0];
            made[n].run_col      = col[POS_W-1:0];
            made[n].run_len      = run[SIDE_W-1:0];
            made[n].colour       = value[1:0] & COLOUR_MASK[1:0];
            made[n].field_done   = 1'b0;
            made[n].last_of_item = 1'b0;
            col = col + run;
            if (col >= w) begin
               col = 0;
               row = (row + 2) & 32'h1FFF;
               if (row >= h) begin
                  field_closed = 1'b1;
                  made[n].field_done = 1'b1;
               end
               n++;
               break;
            end
            n++;
         end
         if (n > 0) made[n-1].last_of_item = 1'b1;
         for (int k = 0; k < n; k++) due_runs.insert(due_runs.size(), made[k]);
         return 1'b1;
      endfunction

      function void compare(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: run %0d %s mismatch, expected %0d actual %0d",
                     $time, runs_checked, name, want, got);
         end
      endfunction

      // check a run taken from the block against the oldest one owed
      function void match_run(run_type got);
         run_type want;
         if (due_runs.size() == 0) begin
            errors++;
            $display("%0t: unexpected run, expected none actual row %0d col %0d len %0d",
                     $time, got.run_row, got.run_col, got.run_len);
            return;
         end
         want = due_runs.pop_front();
         compare("run_row", 32'(want.run_row), 32'(got.run_row));
         compare("run_col", 32'(want.run_col), 32'(got.run_col));
         compare("run_len", 32'(want.run_len), 32'(got.run_len));
         compare("colour", 32'(want.colour), 32'(got.colour));
         compare("field_done", 32'(want.field_done), 32'(got.field_done));
         compare("last_of_item", 32'(want.last_of_item), 32'(got.last_of_item));
         if (want.field_done) fields_ended++;
         runs_checked++;
      endfunction

      function void flag_leftovers();
         while (due_runs.size() != 0) begin
            errors++;
            $display("%0t: missing run, expected row %0d col %0d len %0d actual none",
                     $time, due_runs[0].run_row, due_runs[0].run_col, due_runs[0].run_len);
            void'(due_runs.pop_front());
         end
      endfunction
   endclass

   field_run_tracker tracker;
   bit steady_sender;
   int bytes_live;
   int bytes_ignored;
   int size_settings;

   // free-running clock, period 8
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop in case the handshakes lock up
   initial begin
      #4000000;
      $display("tb_subpicture_rle_field_decoder: done, errors");
      $finish;
   end

   // offer one request after a random gap (none for a steady sender), wait for it to be taken
   task automatic send_byte(input logic [7:0] b, input logic fs, input logic bf);
      int gap;
      gap = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        = 1'b1;
      req_bus.data_byte    = b;
      req_bus.field_start  = fs;
      req_bus.bottom_field = bf;
      do @(posedge clock); while (!req_bus.ready);
      // the predictor moves at the edge where the decoder accepts the request
      if (tracker.take_byte(b, fs, bf)) bytes_live++;
      else bytes_ignored++;
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   // register write, also issued while a field is still open
   task automatic write_size(input csr_index_type idx, input logic [SIDE_W-1:0] v);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      tracker.set_size(idx, v);
   endtask

   // wait for every owed run, then cover a request that yields none but
   // may still sit in the input register
   task automatic settle();
      while (tracker.due_runs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // random nibbles, at least half of them small so that long codes turn up often
   function automatic logic [3:0] pick_nibble();
      if ($urandom_range(0, 1) == 1) return 4'($urandom_range(0, 15));
      return 4'($urandom_range(0, 3));
   endfunction

   // one size setting, then random field data until enough live bytes
   task automatic run_phase(input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h,
                            input int items, input int pause_at);
      int   live_before;
      logic [7:0] b;
      logic fs;
      logic bf;
      write_size(CSR_PIC_WIDTH, w);
      write_size(CSR_PIC_HEIGHT, h);
      size_settings++;
      live_before = bytes_live;
      while (bytes_live - live_before < items) begin
         // some noise while the field is closed; those bytes are ignored unless they start a field
         if (tracker.field_closed && $urandom_range(0, 9) == 0) begin
            send_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            continue;
         end
         // open a new field when the old one is done, now and then mid-field
         fs = tracker.field_closed || ($urandom_range(0, 49) == 0);
         bf = ($urandom_range(0, 3) == 0);
         b  = {pick_nibble(), pick_nibble()};
         send_byte(b, fs, bf);
         // sender waits until every owed run has been taken
         if (bytes_live - live_before == pause_at)
            while (tracker.due_runs.size() != 0) @(negedge clock);
      end
      settle();
   endtask

   // result side: random stalls, bursts with none, and two long hold-offs
   initial begin : result_sink
      int      gap;
      int      seen;
      run_type got;
      rsp_bus.ready = 1'b0;
      seen = 0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         // long hold so that the result buffer fills and requests back up
         if (seen == 400 || seen == 1400) begin
            rsp_bus.ready = 1'b0;
            repeat (80) @(negedge clock);
         end
         gap = ((seen / 200) % 4 == 3) ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.run_row      = rsp_bus.run_row;
         got.run_col      = rsp_bus.run_col;
         got.run_len      = rsp_bus.run_len;
         got.colour       = rsp_bus.colour;
         got.field_done   = rsp_bus.field_done;
         got.last_of_item = rsp_bus.last_of_item;
         tracker.match_run(got);
         seen++;
      end
   end

   initial begin : stimulus
      tracker = new;
      steady_sender = 1'b0;
      bytes_live = 0;
      bytes_ignored = 0;
      size_settings = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      req_bus.field_start = 1'b0;
      req_bus.bottom_field = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part on a small 8 by 6 picture
      write_size(CSR_PIC_WIDTH, 13'd8);
      write_size(CSR_PIC_HEIGHT, 13'd6);
      size_settings++;
      send_byte(8'h4F, 1'b1, 1'b0);  // top field, two one-nibble codes
      send_byte(8'h1C, 1'b0, 1'b0);  // two-nibble code clipped at line end
      send_byte(8'h07, 1'b0, 1'b0);  // code still open after two nibbles
      send_byte(8'h75, 1'b0, 1'b0);  // three-nibble code ends line on high nibble
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h03, 1'b0, 1'b0);  // four-nibble code with zero run, field ends
      send_byte(8'hAB, 1'b0, 1'b0);  // field closed, byte ignored
      send_byte(8'h13, 1'b1, 1'b1);  // bottom field from row one
      send_byte(8'h0F, 1'b0, 1'b0);
      send_byte(8'hF0, 1'b0, 1'b0);  // long run clipped on the high nibble
      send_byte(8'h03, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);  // largest four-nibble code
      send_byte(8'h8C, 1'b0, 1'b0);  // leaves the column at five
      settle();
      // width shrunk below the column mid-field: a one-pixel run ends the line
      write_size(CSR_PIC_WIDTH, 13'd3);
      send_byte(8'h55, 1'b0, 1'b0);
      send_byte(8'h5A, 1'b1, 1'b0);
      settle();
      // height shrunk to the current row: field closes, byte ignored
      write_size(CSR_PIC_HEIGHT, 13'd2);
      send_byte(8'h66, 1'b0, 1'b0);
      settle();
      // field starting past the bottom is closed at once
      write_size(CSR_PIC_HEIGHT, 13'd1);
      send_byte(8'h77, 1'b1, 1'b1);
      settle();
      // zero sizes behave as one pixel by one line
      write_size(CSR_PIC_WIDTH, 13'd0);
      write_size(CSR_PIC_HEIGHT, 13'd0);
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h04, 1'b0, 1'b0);
      settle();

      // random part across a spread of picture sizes, extremes included
      run_phase(13'd0, 13'd0, 150, -1);
      steady_sender = 1'b1;
      run_phase(13'h1FFF, 13'h1FFF, 150, -1);
      steady_sender = 1'b0;
      run_phase(13'd2, 13'd5, 200, -1);
      run_phase(13'd16, 13'd9, 250, 90);
      run_phase(13'd720, 13'd480, 250, -1);
      steady_sender = 1'b1;
      run_phase(13'd4096, 13'd3, 150, -1);
      steady_sender = 1'b0;
      run_phase(13'd1, 13'd40, 150, -1);
      run_phase(13'd37, 13'd4096, 150, -1);
      repeat (3)
         run_phase(13'($urandom_range(1, 64)), 13'($urandom_range(1, 64)), 150, -1);

      while (tracker.due_runs.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      tracker.flag_leftovers();

      $display("covered %0d decoded and %0d ignored bytes over %0d picture sizes",
               bytes_live, bytes_ignored, size_settings);
      $display("checked %0d runs, %0d of them closing a field",
               tracker.runs_checked, tracker.fields_ended);
      if (tracker.errors == 0) begin
         $display("tb_subpicture_rle_field_decoder: done, clean");
      end else begin
         $display("tb_subpicture_rle_field_decoder: done, errors");
      end
      $finish;
   end

endmodule
